[rtl/core/sact_pkg.sv]
package sact_pkg;

    localparam int SETS_DEF         = 16;
    localparam int WAYS_DEF         = 4;
    localparam int LINE_BYTES_DEF   = 64;
    localparam int ADDRESS_BITS_DEF = 48;
    localparam int STAMP_BITS_DEF   = 32;

    // field widths of the request and result
    localparam int OP_W   = 2;
    localparam int ADDR_W = 48;
    localparam int TS_W   = 32;
    localparam int KIND_W = 3;
    localparam int WAY_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_READ       = 2'd0,
        OP_FILL       = 2'd1,
        OP_INVALIDATE = 2'd2,
        OP_FLUSH      = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        K_HIT         = 3'd0,
        K_MISS        = 3'd1,
        K_WRITEBACK   = 3'd2,
        K_FILLED      = 3'd3,
        K_INVALIDATED = 3'd4,
        K_NOT_FOUND   = 3'd5,
        K_FLUSHED     = 3'd6
    } kind_t;

endpackage

[rtl/core/sact_ram.sv]
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/set_assoc_cache_tag_lru.sv]
// request path: set read, decision, output register, from request accept to first result
// a new request is taken only once the final result of the previous one is in the output register;
//   fill, invalidate and flush-set may emit writeback results before their final result
// the set is one memory row (all ways), read once and written back once per request
// reset: clearing pass writing a zero row to each of the SETS sets, no request taken meanwhile
module set_assoc_cache_tag_lru
    import sact_pkg::*;
#(
    parameter int SETS         = SETS_DEF,
    parameter int WAYS         = WAYS_DEF,
    parameter int LINE_BYTES   = LINE_BYTES_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int STAMP_BITS   = STAMP_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [ADDR_W-1:0] address,
    input  logic [TS_W-1:0]   time_stamp,
    input  logic              fill_dirty,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] kind,
    output logic [WAY_W-1:0]  way,
    output logic [ADDR_W-1:0] line_address,
    output logic              to_next_level,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SETB   = $clog2(SETS);
    localparam int TAG_W  = ADDRESS_BITS - OFF_W - SETB;
    localparam int WIX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W = 2 + TAG_W + STAMP_BITS;
    localparam int ROW_W  = WAYS * LINE_W;

    typedef struct packed {
        logic                  valid;
        logic                  dirty;
        logic [TAG_W-1:0]      tag;
        logic [STAMP_BITS-1:0] stamp;
    } line_t;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [SET_W-1:0] clr_reg, clr_next;
    logic cfg_reg;

    // captured request
    op_t                   op_reg;
    logic [SET_W-1:0]      set_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [STAMP_BITS-1:0] ts_reg;
    logic                  fd_reg;

    line_t [WAYS-1:0] row_reg, row_next;
    logic [ROW_W-1:0] rdata;
    logic             we;
    logic [SET_W-1:0] waddr;
    logic [ROW_W-1:0] wdata;

    // pending results: writeback way list (flush, fill, invalidate), final result
    logic [WAYS-1:0]   wb_reg, wb_next;
    logic [WIX_W-1:0]  fin_way_reg, fin_way_next;
    kind_t             fin_kind_reg, fin_kind_next;
    logic              fin_nxt_reg, fin_nxt_next;

    // output register
    logic              ov_reg;
    kind_t             ok_reg;
    logic [WAY_W-1:0]  ow_reg;
    logic [ADDR_W-1:0] oa_reg;
    logic              on_reg, ol_reg;
    logic              out_load;
    kind_t             lk;
    logic [WAY_W-1:0]  lw;
    logic [ADDR_W-1:0] la;
    logic              ln, ll;

    logic [TAG_W-1:0] in_tag;
    logic [SET_W-1:0] in_set;
    logic in_fire;

    assign in_tag  = address[ADDRESS_BITS-1 -: TAG_W];
    assign in_set  = (SETS > 1) ? SET_W'(address[OFF_W +: SET_W]) : '0;
    assign in_stall = (state_reg != S_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    sact_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (in_set),
        .rdata (rdata)
    );

    // line-aligned address from a tag and a set index
    function automatic logic [ADDR_W-1:0] laddr(input logic [TAG_W-1:0] t,
                                                input logic [SET_W-1:0] s);
        logic [ADDRESS_BITS-1:0] a;
        begin
            a = '0;
            a[ADDRESS_BITS-1 -: TAG_W] = t;
            if (SETS > 1)
            begin
                a[OFF_W +: SETB] = s[SETB-1:0];
            end
            laddr = ADDR_W'(a);
        end
    endfunction

    logic              can_load;
    logic [WIX_W-1:0]  wb_idx;
    logic [WIX_W-1:0]  hit_w, inv_w, old_w;
    logic              hit_f, inv_f;

    assign can_load = !ov_reg || !out_stall;

    always_comb
    begin
        hit_f = 1'b0;
        hit_w = '0;
        inv_f = 1'b0;
        inv_w = '0;
        old_w = '0;
        wb_idx = '0;
        for (int i = WAYS-1; i >= 0; i--)
        begin
            if (row_reg[i].valid && row_reg[i].tag == tag_reg)
            begin
                hit_f = 1'b1;
                hit_w = WIX_W'(i);
            end
            if (!row_reg[i].valid)
            begin
                inv_f = 1'b1;
                inv_w = WIX_W'(i);
            end
            if (wb_reg[i])
            begin
                wb_idx = WIX_W'(i);
            end
        end
        // stamp scan across ways; lowest way wins ties
        for (int i = 1; i < WAYS; i++)
        begin
            if (row_reg[i].stamp < row_reg[old_w].stamp)
            begin
                old_w = WIX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        row_next      = row_reg;
        wb_next       = wb_reg;
        fin_way_next  = fin_way_reg;
        fin_kind_next = fin_kind_reg;
        fin_nxt_next  = fin_nxt_reg;
        we    = 1'b0;
        waddr = set_reg;
        wdata = row_reg;
        out_load = 1'b0;
        lk = K_HIT;
        lw = '0;
        la = '0;
        ln = 1'b0;
        ll = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SET_W'(SETS-1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                row_next   = rdata;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                wb_next = '0;
                fin_nxt_next = 1'b0;
                fin_way_next = '0;
                case (op_reg)
                    OP_READ:
                    begin
                        if (hit_f)
                        begin
                            row_next[hit_w].stamp = ts_reg;
                            fin_kind_next = K_HIT;
                            fin_way_next  = hit_w;
                        end
                        else
                        begin
                            fin_kind_next = K_MISS;
                        end
                    end
                    OP_INVALIDATE:
                    begin
                        if (hit_f)
                        begin
                            wb_next[hit_w] = row_reg[hit_w].dirty;
                            row_next[hit_w].valid = 1'b0;
                            row_next[hit_w].dirty = 1'b0;
                            fin_kind_next = K_INVALIDATED;
                            fin_way_next  = hit_w;
                        end
                        else
                        begin
                            fin_kind_next = K_NOT_FOUND;
                        end
                    end
                    OP_FILL:
                    begin
                        if (inv_f)
                        begin
                            fin_way_next = inv_w;
                        end
                        else
                        begin
                            fin_way_next = old_w;
                            wb_next[old_w] = row_reg[old_w].dirty;
                            fin_nxt_next = cfg_reg;
                        end
                        fin_kind_next = K_FILLED;
                    end
                    OP_FLUSH:
                    begin
                        for (int i = 0; i < WAYS; i++)
                        begin
                            wb_next[i] = row_reg[i].dirty;
                        end
                        fin_kind_next = K_FLUSHED;
                    end
                    default: ;
                endcase
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    out_load = 1'b1;
                    if (wb_reg != '0)
                    begin
                        lk = K_WRITEBACK;
                        lw = WAY_W'(wb_idx);
                        la = laddr(row_reg[wb_idx].tag, set_reg);
                        ln = fin_nxt_reg;
                        wb_next[wb_idx] = 1'b0;
                    end
                    else
                    begin
                        lk = fin_kind_reg;
                        lw = WAY_W'(fin_way_reg);
                        ll = 1'b1;
                        if (op_reg == OP_FILL)
                        begin
                            row_next[fin_way_reg].valid = 1'b1;
                            row_next[fin_way_reg].dirty = fd_reg;
                            row_next[fin_way_reg].tag   = tag_reg;
                            row_next[fin_way_reg].stamp = ts_reg;
                        end
                        if (op_reg == OP_FLUSH)
                        begin
                            for (int i = 0; i < WAYS; i++)
                            begin
                                row_next[i].valid = 1'b0;
                                row_next[i].dirty = 1'b0;
                            end
                        end
                        we    = 1'b1;
                        wdata = row_next;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cfg_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            wb_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            wb_reg    <= wb_next;
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        fin_way_reg  <= fin_way_next;
        fin_kind_reg <= fin_kind_next;
        fin_nxt_reg  <= fin_nxt_next;
        if (in_fire)
        begin
            op_reg  <= op_t'(operation);
            set_reg <= in_set;
            tag_reg <= in_tag;
            ts_reg  <= STAMP_BITS'(time_stamp);
            fd_reg  <= fill_dirty;
        end
        if (out_load)
        begin
            ok_reg <= lk;
            ow_reg <= lw;
            oa_reg <= la;
            on_reg <= ln;
            ol_reg <= ll;
        end
    end

    assign out_valid     = ov_reg;
    assign kind          = ok_reg;
    assign way           = ow_reg;
    assign line_address  = oa_reg;
    assign to_next_level = on_reg;
    assign last          = ol_reg;

endmodule
